// ----- rtl/msub_pkg.sv -----
package msub_pkg;

  // Coordinate and register widths
  localparam int COORD_W = 24;
  localparam int SEG_W   = 20;
  // Magnitude of a coordinate difference
  localparam int MAG_W   = COORD_W + 1;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(1000);

  // Adds a signed magnitude to a base coordinate, keeping the low coordinate bits.
  function automatic logic [COORD_W-1:0] apply_offset(input logic [COORD_W-1:0] base,
                                                      input logic [MAG_W-1:0]   mag,
                                                      input logic               neg);
    logic [MAG_W-1:0] sum;
    sum = {base[COORD_W-1], base} + (neg ? (~mag + MAG_W'(1)) : mag);
    return sum[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/msub_div.sv -----
module msub_div #(
  parameter int DW = 25,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    acc;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dsr;
  logic [VW:0]      trial;
  logic [VW:0]      trial_sub;

  // One restoring step: bring down the next dividend bit and try a subtraction.
  assign trial     = {rem, acc[DW-1]};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial_sub[VW-1:0];
          acc <= {acc[DW-2:0], 1'b1};
        end else begin
          rem <= trial[VW-1:0];
          acc <= {acc[DW-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = acc;
  assign remainder = rem;

endmodule

// ----- rtl/move_segment_subdivider_top.sv -----
// Move segment subdivider.
// Input transactions on s_axis carry one toolpath point (x, y, z in tdata, the extruding
// and layer start flags in tuser). Every point becomes the predecessor of the next.
// An extruding point with a predecessor produces a run of p+1 points on m_axis: the
// start point, p-1 evenly spaced interior points and the end point, marked with tlast.
// The segment count p is found by a search that squares p*segment_length in one shared
// multiplier, one candidate after another; the x and y steps |d|/p come from one shared
// restoring divider, one axis after the other. After a run is set up, one point leaves per
// cycle while the receiver takes them.
// Travel points and layer starts only update the predecessor. During a run s_axis_tready
// stays low until its last point is loaded into the output register, so the next point
// may be accepted while it still waits.
// A stalled receiver holds the output register and pauses the run.
// The cfg channel writes segment_length and is always ready; write it only when idle.
// Reset sets segment_length to 1000 and clears the predecessor.
module move_segment_subdivider_top #(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msub_pkg::SEG_W-1:0]         cfg_data,      // segment_length
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [3*msub_pkg::COORD_W-1:0]     s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic [1:0]                         s_axis_tuser,  // extruding, layer_start
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [3*msub_pkg::COORD_W-1:0]     m_axis_tdata,  // out_x, out_y, out_z
  output logic                               m_axis_tlast
);

  import msub_pkg::*;

  localparam int P_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int LEN_W  = SEG_W + P_W;
  localparam int MUL_W  = (LEN_W > MAG_W) ? LEN_W : MAG_W;
  localparam int PROD_W = 2 * MUL_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQX  = 9'b000000010,
    S_SQY  = 9'b000000100,
    S_SUM  = 9'b000001000,
    S_SQL  = 9'b000010000,
    S_CMP  = 9'b000100000,
    S_DIVX = 9'b001000000,
    S_DIVY = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state;

  logic [SEG_W-1:0]   segment_length;
  logic [COORD_W-1:0] prev_x, prev_y, prev_z;
  logic               prev_valid;
  logic [COORD_W-1:0] start_x, start_y, start_z;
  logic [MAG_W-1:0]   mag_x, mag_y;
  logic               neg_x, neg_y;
  logic [LEN_W-1:0]   len;
  logic [P_W-1:0]     p;
  logic [P_W-1:0]     m;
  logic [PROD_W-1:0]  mul_q;
  logic [PROD_W-1:0]  d2;
  logic [MAG_W-1:0]   qd_x, qd_y, q_x, q_y;
  logic [P_W-1:0]     rd_x, rd_y;
  logic [P_W:0]       r_x, r_y;

  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic               in_accept;
  logic [MAG_W-1:0]   diff_x, diff_y;
  logic [MUL_W-1:0]   mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic               search_end;
  logic               div_start;
  logic [MAG_W-1:0]   div_dividend;
  logic               div_done;
  logic [MAG_W-1:0]   div_q;
  logic [P_W-1:0]     div_r;
  logic               out_load;
  logic [P_W:0]       rn_x, rn_y;

  assign in_x = s_axis_tdata[COORD_W-1:0];
  assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_z = s_axis_tdata[3*COORD_W-1:2*COORD_W];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Signed differences from the predecessor, one bit wider than a coordinate
  assign diff_x = {in_x[COORD_W-1], in_x} - {prev_x[COORD_W-1], prev_x};
  assign diff_y = {in_y[COORD_W-1], in_y} - {prev_y[COORD_W-1], prev_y};

  // Shared squaring unit: operand chosen by the sequencer
  always_comb begin
    case (state)
      S_SQX:   mul_a = MUL_W'(mag_x);
      S_SQY:   mul_a = MUL_W'(mag_y);
      default: mul_a = MUL_W'(len);
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_a);

  assign search_end   = (state == S_CMP) &&
                        ((mul_q >= d2) || (p == P_W'(MAX_SEGMENTS)));
  assign div_start    = search_end || ((state == S_DIVX) && div_done);
  assign div_dividend = (state == S_CMP) ? mag_x : mag_y;

  msub_div #(.DW(MAG_W), .VW(P_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (p),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign out_load = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign rn_x     = r_x + {1'b0, rd_x};
  assign rn_y     = r_y + {1'b0, rd_y};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      segment_length <= cfg_data;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_valid <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_z     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            prev_x     <= in_x;
            prev_y     <= in_y;
            prev_z     <= in_z;
            prev_valid <= 1'b1;
            start_x    <= prev_x;
            start_y    <= prev_y;
            start_z    <= prev_z;
            neg_x      <= diff_x[MAG_W-1];
            neg_y      <= diff_y[MAG_W-1];
            mag_x      <= diff_x[MAG_W-1] ? (~diff_x + MAG_W'(1)) : diff_x;
            mag_y      <= diff_y[MAG_W-1] ? (~diff_y + MAG_W'(1)) : diff_y;
            if (s_axis_tuser[0] && !s_axis_tuser[1] && prev_valid) begin
              state <= S_SQX;
            end
          end
        end
        S_SQX: begin
          mul_q <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          d2    <= mul_q;
          mul_q <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          d2    <= d2 + mul_q;
          p     <= P_W'(1);
          len   <= LEN_W'(segment_length);
          state <= S_SQL;
        end
        S_SQL: begin
          mul_q <= mul_p;
          state <= S_CMP;
        end
        S_CMP: begin
          if (search_end) begin
            state <= S_DIVX;
          end else begin
            p     <= p + P_W'(1);
            len   <= len + LEN_W'(segment_length);
            state <= S_SQL;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            qd_x  <= div_q;
            rd_x  <= div_r;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            qd_y  <= div_q;
            rd_y  <= div_r;
            q_x   <= '0;
            q_y   <= '0;
            r_x   <= '0;
            r_y   <= '0;
            m     <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            // Step the running quotient and remainder to the next point
            if (rn_x >= {1'b0, p}) begin
              r_x <= rn_x - {1'b0, p};
              q_x <= q_x + qd_x + MAG_W'(1);
            end else begin
              r_x <= rn_x;
              q_x <= q_x + qd_x;
            end
            if (rn_y >= {1'b0, p}) begin
              r_y <= rn_y - {1'b0, p};
              q_y <= q_y + qd_y + MAG_W'(1);
            end else begin
              r_y <= rn_y;
              q_y <= q_y + qd_y;
            end
            m <= m + P_W'(1);
            if (m == p) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      if (m == '0) begin
        m_axis_tdata <= {start_z, start_y, start_x};
        m_axis_tlast <= 1'b0;
      end else if (m == p) begin
        m_axis_tdata <= {prev_z, prev_y, prev_x};
        m_axis_tlast <= 1'b1;
      end else begin
        m_axis_tdata <= {start_z,
                         apply_offset(start_y, q_y, neg_y),
                         apply_offset(start_x, q_x, neg_x)};
        m_axis_tlast <= 1'b0;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

// ----- verif/msub_checker.sv -----
// Watches the configuration, input and output channels of the subdivider, predicts
// the emitted point runs and compares every output transaction with the oldest
// expected point.
module msub_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [msub_pkg::SEG_W-1:0]         cfg_data,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [3*msub_pkg::COORD_W-1:0]     s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic [1:0]                         s_axis_tuser,  // extruding, layer_start
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [3*msub_pkg::COORD_W-1:0]     m_axis_tdata,  // out_x, out_y, out_z
  input  logic                               m_axis_tlast,
  output int                                 errors,
  output int                                 points_waiting,
  output int                                 runs_seen,
  output int                                 points_seen,
  output int                                 longest_run
);
  timeunit 1ns;
  timeprecision 1ps;

  import msub_pkg::*;

  localparam int MAX_SEGMENTS = 63;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } point_t;

  point_t expected_points[$];

  // Shadow of the block's register and predecessor point.
  logic [SEG_W-1:0]          seg_len;
  logic signed [COORD_W-1:0] last_x, last_y, last_z;
  logic                      have_last;

  // Appends the points that one accepted input point produces.
  function automatic void subdivide_move(logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic signed [COORD_W-1:0] z,
                                         logic extr, logic lstart);
    longint dx, dy, dist2, len, segs;
    point_t pt;
    if (extr && !lstart && have_last) begin
      dx = longint'(x) - longint'(last_x);
      dy = longint'(y) - longint'(last_y);
      dist2 = dx * dx + dy * dy;
      segs = 1;
      while (segs < MAX_SEGMENTS) begin
        len = segs * longint'(seg_len);
        if (len * len >= dist2) break;
        segs++;
      end
      pt = '{last_x, last_y, last_z, 1'b0};
      expected_points.push_back(pt);
      for (longint m = 1; m < segs; m++) begin
        pt.x = COORD_W'(longint'(last_x) + (m * dx) / segs);
        pt.y = COORD_W'(longint'(last_y) + (m * dy) / segs);
        expected_points.push_back(pt);
      end
      pt = '{x, y, z, 1'b1};
      expected_points.push_back(pt);
      runs_seen++;
      if (segs > longest_run) longest_run = int'(segs);
    end
  endfunction

  always @(posedge clk) begin
    point_t want, got;
    if (rst) begin
      seg_len = SEG_RESET;
      last_x = '0;
      last_y = '0;
      last_z = '0;
      have_last = 1'b0;
      expected_points.delete();
      errors = 0;
      runs_seen = 0;
      points_seen = 0;
      longest_run = 0;
    end else begin
      // Output transaction first: it can only belong to an earlier input point.
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W],
                m_axis_tdata[3*COORD_W-1:2*COORD_W], m_axis_tlast};
        points_seen++;
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected point x=%0d y=%0d z=%0d last=%0b", $realtime,
                     $signed(got.x), $signed(got.y), $signed(got.z), got.last);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: point mismatch, expected x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
                       $realtime, $signed(want.x), $signed(want.y), $signed(want.z),
                       want.last, $signed(got.x), $signed(got.y), $signed(got.z), got.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        subdivide_move(s_axis_tdata[COORD_W-1:0], s_axis_tdata[2*COORD_W-1:COORD_W],
                       s_axis_tdata[3*COORD_W-1:2*COORD_W], s_axis_tuser[0],
                       s_axis_tuser[1]);
        last_x = s_axis_tdata[COORD_W-1:0];
        last_y = s_axis_tdata[2*COORD_W-1:COORD_W];
        last_z = s_axis_tdata[3*COORD_W-1:2*COORD_W];
        have_last = 1'b1;
      end
      if (cfg_valid && cfg_ready) seg_len = cfg_data;
    end
    points_waiting = expected_points.size();
  end

endmodule

// ----- verif/tb.sv -----
// Stimulus and verdict for the move segment subdivider.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msub_pkg::*;

  localparam longint COORD_MIN = -8388608;
  localparam longint COORD_MAX = 8388607;
  localparam int     SETTLE    = 300;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [SEG_W-1:0]         cfg_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [3*COORD_W-1:0]     s_axis_tdata = '0;  // pos_x, pos_y, pos_z
  logic [1:0]               s_axis_tuser = '0;  // extruding, layer_start
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [3*COORD_W-1:0]     m_axis_tdata;       // out_x, out_y, out_z
  logic                     m_axis_tlast;

  int errors, points_waiting, runs_seen, points_seen, longest_run;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int points_sent = 0;
  longint cur_x = 0, cur_y = 0, cur_z = 0;

  move_segment_subdivider_top dut (.*);

  msub_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Sends one point and waits for its transaction.
  task automatic send_point(longint x, longint y, longint z, bit extr, bit lstart);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
    s_axis_tuser <= {lstart, extr};
    do @(posedge clk); while (!s_axis_tready);
    cur_x = x;
    cur_y = y;
    cur_z = z;
    points_sent++;
  endtask

  // Holds off until every expected point has left and the block has settled.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (points_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seg_len(int unsigned value);
    cfg_valid <= 1'b1;
    cfg_data <= SEG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Mostly well-formed extruding paths with steps of up to 70 segment lengths per axis.
  task automatic random_point(int unsigned seg);
    int unsigned kind;
    longint reach;
    kind = $urandom_range(99);
    reach = longint'(seg) * longint'($urandom_range(70));
    if (kind < 80) begin
      send_point(clamp_coord(cur_x + longint'($urandom_range(2 * reach)) - reach),
                 clamp_coord(cur_y + longint'($urandom_range(2 * reach)) - reach),
                 clamp_coord(cur_z + longint'($urandom_range(20)) - 10), 1'b1, 1'b0);
    end else if (kind < 88) begin
      send_point(clamp_coord(cur_x + longint'($urandom_range(2 * reach)) - reach),
                 clamp_coord(cur_y + longint'($urandom_range(2 * reach)) - reach),
                 cur_z, 1'b0, 1'b0);
    end else if (kind < 93) begin
      send_point(cur_x, cur_y, cur_z + 200, $urandom_range(1), 1'b1);
    end else begin
      send_point(longint'(signed'(COORD_W'($urandom))),
                 longint'(signed'(COORD_W'($urandom))),
                 longint'(signed'(COORD_W'($urandom))), $urandom_range(1),
                 $urandom_range(1));
    end
  endtask

  initial begin
    int unsigned seg_plan[6] = '{1, 1048575, 37, 1000, 250, 5000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points at the reset segment length.
    send_point(0, 0, 0, 1'b1, 1'b0);                  // no predecessor yet
    send_point(1000, 0, 0, 1'b1, 1'b0);
    send_point(1000, 0, 0, 1'b1, 1'b0);               // zero-length move
    send_point(3500, -2500, 10, 1'b1, 1'b0);
    send_point(-7, -3, 10, 1'b1, 1'b0);               // negative steps truncate
    send_point(100, 100, 0, 1'b0, 1'b0);              // travel
    send_point(0, 0, 0, 1'b1, 1'b1);                  // layer start
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 0, 1'b1, 1'b0);
    send_point(5, 5, 5, 1'b0, 1'b1);
    send_point(5, 6, 5, 1'b1, 1'b0);
    send_point(12, -19, 7, 1'b1, 1'b0);
    send_point(2012, 1981, 7, 1'b1, 1'b0);
    send_point(-9000, 45000, -3, 1'b1, 1'b0);
    drain();

    // Random phases, each at its own segment length, with one of three idling patterns.
    foreach (seg_plan[i]) begin
      write_seg_len(seg_plan[i]);
      if (i < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 75;
      end else if (i < 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (76) random_point(seg_plan[i]);
      drain();
    end

    $display("Sent %0d points over six segment lengths from 1 to 1048575;", points_sent);
    $display("checked %0d emitted points in %0d runs, longest run %0d segments.",
             points_seen, runs_seen, longest_run);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
